### src/prs_pkg.sv
// Shared types and constants for the prefix range search block.
// Depends on nothing; every other file refers to it by scoped names.
package prs_pkg;

  // Fixed widths of the item fields and the configuration register.
  localparam int unsigned OP_W     = 1;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned KEY_IN_W = 48;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned CNT_W    = 13;

  // Keys are left-justified into this width before bytes are compared.
  localparam int unsigned KEY_ALN_W = 64;
  localparam int unsigned LEN_CAP_W = 4;
  localparam int unsigned CMP_BYTES = KEY_ALN_W / 8;

  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BS_RD,
    ST_BS_CMP,
    ST_SC_RD,
    ST_SC_CMP,
    ST_DONE
  } state_e;

endpackage

### src/prs_if.sv
// Valid/ready channel interfaces for search and write items and for results.
// Depends on prs_pkg for the field widths.
interface prs_in_if;
  logic                           valid;
  logic                           ready;
  logic [prs_pkg::OP_W-1:0]       operation;
  logic [prs_pkg::IDX_W-1:0]      entry_index;
  logic [prs_pkg::KEY_IN_W-1:0]   key_bytes;
  logic [prs_pkg::LEN_W-1:0]      prefix_length;

  modport source (output valid, operation, entry_index, key_bytes, prefix_length,
                  input ready);
  modport sink   (input valid, operation, entry_index, key_bytes, prefix_length,
                  output ready);
endinterface

interface prs_out_if;
  logic                        valid;
  logic                        ready;
  logic [prs_pkg::CNT_W-1:0]   first_match_res;
  logic [prs_pkg::CNT_W-1:0]   match_count;

  modport source (output valid, first_match_res, match_count, input ready);
  modport sink   (input valid, first_match_res, match_count, output ready);
endinterface

### src/prs_key_cmp.sv
// Byte-wise prefix comparison of a table key against a search prefix.
// Depends on prs_pkg; both operands arrive left-justified.
module prs_key_cmp (
  input  logic [prs_pkg::KEY_ALN_W-1:0] entry_i,
  input  logic [prs_pkg::KEY_ALN_W-1:0] prefix_i,
  input  logic [prs_pkg::LEN_CAP_W-1:0] len_i,
  output prs_pkg::cmp_e                 result_o
);

  always_comb begin
    logic       done;
    logic [7:0] a;
    logic [7:0] p;
    done     = 1'b0;
    result_o = prs_pkg::CMP_EQ;
    for (int b = 0; b < prs_pkg::CMP_BYTES; b++) begin
      a = entry_i[prs_pkg::KEY_ALN_W-1-8*b -: 8];
      p = prefix_i[prs_pkg::KEY_ALN_W-1-8*b -: 8];
      if (!done && (b < int'(len_i))) begin
        if (a != p) begin
          result_o = (a < p) ? prs_pkg::CMP_LT : prs_pkg::CMP_GT;
          done     = 1'b1;
        end else if (a == 8'd0) begin
          // A matching null byte ends the key, so the rest compares equal.
          done = 1'b1;
        end
      end
    end
  end

endmodule

### src/prefix_range_search_core.sv
// Top level of the prefix range search block: key table memory and sequencer.
// Depends on prs_pkg, the channel interfaces in prs_if and prs_key_cmp.
//
// Usage: items arrive on in_i. A write item stores key_bytes at entry_index
// in the key table and produces no result; a slot at or beyond MAX_ENTRIES
// is ignored. A search item produces one result on out_o: the lower bound
// of the prefix over the first record_count entries and the number of
// consecutive entries from there that share the prefix. The record count
// is loaded through cfg_we_i/cfg_wdata_i; the user must load it only while
// the block is idle, which the block itself does not enforce. A write
// leaves the block idle, so writes are accepted back to back. A search runs
// a halving search over the key table, each probe a read state and a compare
// state, then scans forward entry by entry while the entries match the
// prefix, and at last loads the output register. No new item is accepted
// until the search has loaded its result. The key table has a single read
// port with a registered read, which the probes and the scan share.
// Reset clears the record count and the sequencer; the table itself is not
// cleared. A result waits in the output register while out_o is stalled,
// and the next item is accepted meanwhile; a later search then waits to
// hand over its result until the register is free.
module prefix_range_search_core #(
  parameter int unsigned MAX_ENTRIES   = 4096,
  parameter int unsigned KEY_LEN_BYTES = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [prs_pkg::CNT_W-1:0] cfg_wdata_i,
  prs_in_if.sink                    in_i,
  prs_out_if.source                 out_o
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KEY_W = 8 * KEY_LEN_BYTES;

  prs_pkg::state_e state_q, state_d;

  logic [prs_pkg::CNT_W-1:0]     rc_q;
  logic                          out_valid_q, out_valid_d;
  logic [prs_pkg::CNT_W-1:0]     first_q, first_d;
  logic [prs_pkg::CNT_W-1:0]     count_q, count_d;

  logic [CW-1:0]                 lo_q, lo_d;
  logic [CW-1:0]                 hi_q, hi_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 total_q, total_d;
  logic [prs_pkg::KEY_ALN_W-1:0] pfx_q, pfx_d;
  logic [prs_pkg::LEN_CAP_W-1:0] len_q, len_d;

  logic [KEY_W-1:0]              mem_q [MAX_ENTRIES];
  logic [KEY_W-1:0]              rdata_q;
  logic [AW-1:0]                 raddr;
  logic                          mem_we;
  logic [AW-1:0]                 waddr;
  logic [KEY_W-1:0]              wdata;

  logic                          in_fire;
  logic [prs_pkg::KEY_ALN_W-1:0] key_ext;
  logic [KEY_W-1:0]              key_trim;
  logic [CW:0]                   mid_sum;
  logic [CW-1:0]                 mid;
  logic [CW-1:0]                 span;
  logic [31:0]                   lo_32;
  logic [31:0]                   span_32;
  logic [prs_pkg::KEY_ALN_W-1:0] entry_aln;
  prs_pkg::cmp_e                 cmp_res;

  assign in_i.ready            = (state_q == prs_pkg::ST_IDLE);
  assign in_fire               = in_i.valid && in_i.ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.first_match_res = first_q;
  assign out_o.match_count     = count_q;

  assign key_ext  = prs_pkg::KEY_ALN_W'(in_i.key_bytes);
  assign key_trim = key_ext[KEY_W-1:0];

  assign mem_we = in_fire && (in_i.operation == prs_pkg::OP_WRITE)
                  && (32'(in_i.entry_index) < MAX_ENTRIES);
  assign waddr  = AW'(32'(in_i.entry_index));
  assign wdata  = key_trim;

  assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
  assign mid     = mid_sum[CW:1];
  assign raddr   = (state_q == prs_pkg::ST_SC_RD) ? AW'(32'(idx_q)) : AW'(32'(mid));

  assign span    = idx_q - lo_q;
  assign lo_32   = 32'(lo_q);
  assign span_32 = 32'(span);

  // Table keys are left-justified so byte 0 sits at the top of the word.
  assign entry_aln = prs_pkg::KEY_ALN_W'(rdata_q) << (prs_pkg::KEY_ALN_W - KEY_W);

  prs_key_cmp u_cmp (
    .entry_i  (entry_aln),
    .prefix_i (pfx_q),
    .len_i    (len_q),
    .result_o (cmp_res)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prs_pkg::ST_IDLE;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    idx_q   <= idx_d;
    total_q <= total_d;
    pfx_q   <= pfx_d;
    len_q   <= len_d;
    first_q <= first_d;
    count_q <= count_d;
  end

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    total_d     = total_q;
    pfx_d       = pfx_q;
    len_d       = len_q;
    first_d     = first_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      prs_pkg::ST_IDLE: begin
        if (in_fire && (in_i.operation == prs_pkg::OP_SEARCH)) begin
          total_d = (32'(rc_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(32'(rc_q));
          pfx_d   = prs_pkg::KEY_ALN_W'(key_trim) << (prs_pkg::KEY_ALN_W - KEY_W);
          len_d   = (32'(in_i.prefix_length) > KEY_LEN_BYTES)
                    ? prs_pkg::LEN_CAP_W'(KEY_LEN_BYTES)
                    : prs_pkg::LEN_CAP_W'(in_i.prefix_length);
          lo_d    = '0;
          if (in_i.prefix_length == '0) begin
            // An empty prefix matches the whole table without a lookup.
            idx_d   = total_d;
            state_d = prs_pkg::ST_DONE;
          end else begin
            hi_d    = total_d;
            state_d = prs_pkg::ST_BS_RD;
          end
        end
      end
      prs_pkg::ST_BS_RD: begin
        if (lo_q < hi_q) begin
          state_d = prs_pkg::ST_BS_CMP;
        end else begin
          idx_d   = lo_q;
          state_d = prs_pkg::ST_SC_RD;
        end
      end
      prs_pkg::ST_BS_CMP: begin
        if (cmp_res == prs_pkg::CMP_LT) begin
          lo_d = mid + CW'(1);
        end else begin
          hi_d = mid;
        end
        state_d = prs_pkg::ST_BS_RD;
      end
      prs_pkg::ST_SC_RD: begin
        state_d = (idx_q < total_q) ? prs_pkg::ST_SC_CMP : prs_pkg::ST_DONE;
      end
      prs_pkg::ST_SC_CMP: begin
        if (cmp_res == prs_pkg::CMP_EQ) begin
          idx_d   = idx_q + CW'(1);
          state_d = prs_pkg::ST_SC_RD;
        end else begin
          state_d = prs_pkg::ST_DONE;
        end
      end
      prs_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          first_d     = lo_32[prs_pkg::CNT_W-1:0];
          count_d     = span_32[prs_pkg::CNT_W-1:0];
          out_valid_d = 1'b1;
          state_d     = prs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = prs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sim/prefix_range_search_core_tb.sv
// Self-checking bench for prefix_range_search_core: fills the key table, sets record counts
// and checks every search result in order against an in-bench lower-bound predictor.
// Depends on prs_pkg, the channel interfaces in prs_if and the block itself.
module prefix_range_search_core_tb;

  localparam int unsigned TABLE_DEPTH   = 4096;
  localparam int unsigned KEY_BYTES     = 6;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  typedef bit [prs_pkg::KEY_IN_W-1:0] key_t;
  typedef bit [prs_pkg::CNT_W-1:0]    cnt_t;

  typedef struct packed {
    cnt_t first;
    cnt_t count;
  } key_range_t;

  class range_scoreboard;
    key_t        keys [TABLE_DEPTH];
    cnt_t        record_count;
    key_range_t  expected_ranges [$];
    int unsigned errors;

    // Byte-wise unsigned comparison; a zero byte held by both sides ends it as equal.
    function prs_pkg::cmp_e compare_key(key_t entry, key_t pfx, int unsigned len);
      bit [7:0] a;
      bit [7:0] b;
      for (int unsigned i = 0; i < len; i++) begin
        a = entry[8*(KEY_BYTES-1-i) +: 8];
        b = pfx[8*(KEY_BYTES-1-i) +: 8];
        if (a != b) return (a < b) ? prs_pkg::CMP_LT : prs_pkg::CMP_GT;
        if (a == 8'h00) return prs_pkg::CMP_EQ;
      end
      return prs_pkg::CMP_EQ;
    endfunction

    function void note_item(bit [prs_pkg::OP_W-1:0] op, bit [prs_pkg::IDX_W-1:0] idx,
                            key_t k, bit [prs_pkg::LEN_W-1:0] len);
      int unsigned total;
      int unsigned plen;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned run;
      key_range_t  r;
      if (op == prs_pkg::OP_WRITE) begin
        keys[idx] = k;
        return;
      end
      total = (record_count > TABLE_DEPTH) ? TABLE_DEPTH : record_count;
      plen  = (len > KEY_BYTES) ? KEY_BYTES : len;
      lo    = 0;
      run   = total;
      if (plen != 0) begin
        hi = total;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (compare_key(keys[mid], k, plen) == prs_pkg::CMP_LT) lo = mid + 1;
          else hi = mid;
        end
        run = lo;
        while (run < total && compare_key(keys[run], k, plen) == prs_pkg::CMP_EQ) run++;
      end
      r.first = cnt_t'(lo);
      r.count = cnt_t'(run - lo);
      expected_ranges.push_back(r);
    endfunction

    function void check_range(logic [prs_pkg::CNT_W-1:0] first,
                              logic [prs_pkg::CNT_W-1:0] count);
      key_range_t exp_r;
      if (expected_ranges.size() == 0) begin
        errors++;
        $display("%0t: result first_match_res %0d match_count %0d with no search outstanding",
                 $time, first, count);
        return;
      end
      exp_r = expected_ranges.pop_front();
      if (first !== exp_r.first) begin
        errors++;
        $display("%0t: first_match_res expected %0d, actual %0d", $time, exp_r.first, first);
      end
      if (count !== exp_r.count) begin
        errors++;
        $display("%0t: match_count expected %0d, actual %0d", $time, exp_r.count, count);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [prs_pkg::CNT_W-1:0] cfg_wdata;
  int unsigned               src_idle_pct;
  int unsigned               rx_stall_pct;
  bit                        rx_hold_req;
  int unsigned               cycle_count;
  range_scoreboard           sb;

  prs_in_if  in_ch ();
  prs_out_if out_ch ();

  prefix_range_search_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("prefix_range_search_core_tb: errors");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_range(out_ch.first_match_res, out_ch.match_count);
      if (rx_hold_req) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(bit [prs_pkg::OP_W-1:0] op, bit [prs_pkg::IDX_W-1:0] idx,
                           key_t k, bit [prs_pkg::LEN_W-1:0] len);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.entry_index   <= idx;
    in_ch.key_bytes     <= k;
    in_ch.prefix_length <= len;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_item(op, idx, k, len);
  endtask

  task automatic write_key(bit [prs_pkg::IDX_W-1:0] idx, key_t k);
    send_item(prs_pkg::OP_WRITE, idx, k, prs_pkg::LEN_W'($urandom));
  endtask

  task automatic search(key_t pfx, bit [prs_pkg::LEN_W-1:0] len);
    send_item(prs_pkg::OP_SEARCH, prs_pkg::IDX_W'($urandom), pfx, len);
  endtask

  // Waits until every search has been answered and the block has gone quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_record_count(cnt_t value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.record_count = value;
  endtask

  // Short keys over a tiny alphabet, so that shared prefixes and duplicates are common.
  function automatic key_t random_symbol();
    key_t        k;
    int unsigned len;
    if ($urandom_range(0, 9) == 0) return key_t'({$urandom, $urandom});
    k   = '0;
    len = $urandom_range(0, KEY_BYTES);
    for (int unsigned i = 0; i < len; i++)
      k[8*(KEY_BYTES-1-i) +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                               : 8'h41 + 8'($urandom_range(0, 2));
    return k;
  endfunction

  task automatic build_table(int unsigned n, bit unsorted);
    key_t        ordered [$];
    key_t        k;
    int unsigned pos;
    for (int unsigned i = 0; i < n; i++) begin
      k   = random_symbol();
      pos = 0;
      if (!unsorted)
        while (pos < ordered.size() && ordered[pos] <= k) pos++;
      ordered.insert(pos, k);
    end
    for (int unsigned i = 0; i < n; i++) write_key(prs_pkg::IDX_W'(i), ordered[i]);
  endtask

  // Most prefixes are cut from a live entry, with junk beyond the compared bytes.
  task automatic random_search();
    int unsigned span;
    int unsigned len;
    key_t        keep;
    key_t        pfx;
    span = (sb.record_count > TABLE_DEPTH) ? TABLE_DEPTH : sb.record_count;
    if (span != 0 && $urandom_range(0, 3) != 0) begin
      len  = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 7);
      keep = (len >= KEY_BYTES) ? '1 : ~(48'hFFFF_FFFF_FFFF >> (8 * len));
      pfx  = (sb.keys[$urandom_range(0, span - 1)] & keep) | (key_t'({$urandom, $urandom}) & ~keep);
      // Nudging the last compared byte lands the search just beside a run of matches.
      if (len != 0 && len <= KEY_BYTES && $urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 0) pfx = pfx + (key_t'(1) << (8 * (KEY_BYTES - len)));
        else pfx = pfx - (key_t'(1) << (8 * (KEY_BYTES - len)));
      end
    end else begin
      pfx = random_symbol();
      len = $urandom_range(0, 7);
    end
    search(pfx, prs_pkg::LEN_W'(len));
  endtask

  initial begin : stimulus
    int unsigned rc;
    sb = new;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= prs_pkg::OP_WRITE;
    in_ch.entry_index   <= '0;
    in_ch.key_bytes     <= '0;
    in_ch.prefix_length <= '0;
    src_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, then a small table with padding, duplicates and extremes.
    search(48'h4142_4300_0000, 3'd3);
    search(48'h4142_4300_0000, 3'd0);
    write_key(12'd0, 48'h0000_0000_0000);
    write_key(12'd1, 48'h4100_0000_0000);
    write_key(12'd2, 48'h4142_0000_0000);
    write_key(12'd3, 48'h4142_4300_0000);
    write_key(12'd4, 48'h4142_4445_4647);
    write_key(12'd5, 48'h4200_0000_0000);
    write_key(12'd6, 48'hFFFF_FFFF_FFFF);
    write_key(12'd7, 48'hFFFF_FFFF_FFFF);
    write_key(12'd4095, 48'hAAAA_AA55_5555);
    load_record_count(13'd8);
    search(48'h1234_5678_9ABC, 3'd0);
    search(48'h41FF_FFFF_FFFF, 3'd1);
    search(48'h4142_9999_9999, 3'd2);
    search(48'h4142_4300_5A5A, 3'd6);
    search(48'hFFFF_FFFF_FFFF, 3'd7);
    search(48'h0000_0000_0000, 3'd6);
    search(48'h4300_0000_0000, 3'd1);

    // Record counts at and above the table depth, with empty prefixes that read no entry.
    load_record_count(13'd4096);
    repeat (4) search(key_t'({$urandom, $urandom}), 3'd0);
    load_record_count(13'h1FFF);
    repeat (4) search(key_t'({$urandom, $urandom}), 3'd0);

    for (int unsigned ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          src_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 70;
          rx_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          rx_stall_pct = 70;
        end
        default: begin
          src_idle_pct = 13;
          rx_stall_pct = 13;
        end
      endcase
      if (ph == 0) rc = 1;
      else if (ph == 3) rc = 64;
      else if (ph == 11) rc = 0;
      else rc = $urandom_range(2, 48);
      build_table(rc, ph == 5 || ph == 9);
      load_record_count(cnt_t'(rc));
      for (int unsigned s = 0; s < 55; s++) begin
        if (ph == 2 && s == 12) rx_hold_req = 1'b1;
        if (ph == 6 && s == 25) settle();
        if ($urandom_range(0, 19) == 0) write_key(prs_pkg::IDX_W'($urandom), random_symbol());
        else random_search();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("prefix_range_search_core_tb: clean");
    end else begin
      $display("prefix_range_search_core_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/prs_pkg.sv
src/prs_if.sv
src/prs_key_cmp.sv
src/prefix_range_search_core.sv
sim/prefix_range_search_core_tb.sv
